// ===== hdl/rmsam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmsam_pkg
// Shared widths and constants for the RMS amplitude meter.
// ----------------------------------------------------------------------------
package rmsam_pkg;

    localparam int RAW_W = 10;
    localparam int AMP_W = 15;

    localparam logic [RAW_W-1:0] SAMPLE_OFFSET = RAW_W'(512);

    localparam int SQ_W       = 2 * RAW_W - 1;
    localparam int NUM_SHIFT  = 41;
    localparam int QUO_W      = 30;
    localparam int ITER_W     = 5;

    localparam logic [QUO_W-1:0] FULL_SCALE_SQ  = 30'd1073676289;
    localparam logic [QUO_W-1:0] ROOT_ONE_INIT  = 30'h1000_0000;

    localparam logic [ITER_W-1:0] DIV_LAST_BIT  = ITER_W'(QUO_W - 1);
    localparam logic [ITER_W-1:0] ROOT_STEPS    = ITER_W'(QUO_W / 2 - 1);

endpackage : rmsam_pkg
`default_nettype wire

// ===== hdl/rmsam_sample_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmsam_sample_if
// Valid/ready channel carrying one converter sample per beat.
// ----------------------------------------------------------------------------
interface rmsam_sample_if;
    import rmsam_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_sample;
    logic             last_in_buffer;

    modport source (
        output valid,
        output raw_sample,
        output last_in_buffer,
        input  ready
    );

    modport sink (
        input  valid,
        input  raw_sample,
        input  last_in_buffer,
        output ready
    );
endinterface : rmsam_sample_if
`default_nettype wire

// ===== hdl/rmsam_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmsam_result_if
// Valid/ready channel carrying one amplitude result per beat.
// ----------------------------------------------------------------------------
interface rmsam_result_if;
    import rmsam_pkg::*;

    logic             valid;
    logic             ready;
    logic [AMP_W-1:0] amplitude;
    logic             history_full;

    modport source (
        output valid,
        output amplitude,
        output history_full,
        input  ready
    );

    modport sink (
        input  valid,
        input  amplitude,
        input  history_full,
        output ready
    );
endinterface : rmsam_result_if
`default_nettype wire

// ===== hdl/rms_amplitude_meter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rms_amplitude_meter
// Per-buffer RMS level in Q1.14 with a moving average over recent buffers.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while the meter accumulates. After the beat
// flagged last_in_buffer the meter stops taking samples while it works out the
// level, and also its mean when the history holds no zero entry; one shared
// compare-and-subtract unit runs a 30-step division by count * 32767^2 and a
// 15-step square root, and the mean comes from one multiplication by the
// reciprocal of HISTORY_DEPTH.
// Sampling resumes once the result is placed in the output register, which
// waits there for the sink; a full output register adds cycles of waiting.
// ----------------------------------------------------------------------------
module rms_amplitude_meter #(
    parameter int HISTORY_DEPTH      = 8,
    parameter int MAX_BUFFER_SAMPLES = 65536
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rmsam_sample_if.sink   samples,
    rmsam_result_if.source levels
);
    import rmsam_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BUFFER_SAMPLES + 1);
    localparam int DSUM_W = SQ_W + CNT_W;
    localparam int NUM_W  = DSUM_W + NUM_SHIFT;
    localparam int PROD_W = CNT_W + QUO_W;
    localparam int TOT_W  = AMP_W + $clog2(HISTORY_DEPTH);
    localparam int ZC_W   = $clog2(HISTORY_DEPTH + 1);

    localparam int MEAN_SHIFT = TOT_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W    = MEAN_SHIFT + 1;
    localparam int MPROD_W    = TOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'((2 ** MEAN_SHIFT + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

    typedef enum logic [6:0] {
        S_ACC   = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_ROOT  = 7'b0001000,
        S_PUSH  = 7'b0010000,
        S_MEAN  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [DSUM_W-1:0]  dsum_reg, dsum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [AMP_W-1:0]   hist_reg [HISTORY_DEPTH];
    logic [AMP_W-1:0]   hist_next [HISTORY_DEPTH];
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [ZC_W-1:0]    zeros_reg, zeros_next;
    logic               out_valid_reg, out_valid_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;

    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   dsh_reg, dsh_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [QUO_W-1:0]   root_reg, root_next;
    logic [QUO_W-1:0]   one_reg, one_next;
    logic [AMP_W-1:0]   res_amp_reg, res_amp_next;
    logic               res_full_reg, res_full_next;
    logic [AMP_W-1:0]   out_amp_reg, out_amp_next;
    logic               out_full_reg, out_full_next;

    logic               take;
    logic [RAW_W-1:0]   mag;
    logic [SQ_W-1:0]    sq;
    logic [PROD_W-1:0]  scale_prod;
    logic [NUM_W-1:0]   sub_b;
    logic [NUM_W:0]     sub_diff;
    logic               sub_ok;
    logic [QUO_W-1:0]   quo_step;
    logic [AMP_W-1:0]   amp;
    logic [AMP_W-1:0]   oldest;
    logic [ZC_W-1:0]    zeros_upd;
    logic [TOT_W-1:0]   total_upd;
    logic [MPROD_W-1:0] mean_prod;
    logic               out_free;

    assign samples.ready      = (state_reg == S_ACC);
    assign levels.valid       = out_valid_reg;
    assign levels.amplitude   = out_amp_reg;
    assign levels.history_full = out_full_reg;

    assign take     = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || levels.ready;

    assign mag = samples.raw_sample[RAW_W-1]
               ? {1'b0, samples.raw_sample[RAW_W-2:0]}
               : SAMPLE_OFFSET - samples.raw_sample;
    assign sq  = SQ_W'(mag) * SQ_W'(mag);

    assign scale_prod = PROD_W'(count_reg) * PROD_W'(FULL_SCALE_SQ);

    // shared compare-and-subtract unit
    assign sub_b    = (state_reg == S_ROOT) ? NUM_W'(root_reg + one_reg) : dsh_reg;
    assign sub_diff = {1'b0, rem_reg} - {1'b0, sub_b};
    assign sub_ok   = !sub_diff[NUM_W];
    assign quo_step = {quo_reg[QUO_W-2:0], sub_ok};

    assign amp       = root_reg[AMP_W-1:0];
    assign oldest    = hist_reg[0];
    assign zeros_upd = zeros_reg - ZC_W'(oldest == '0) + ZC_W'(amp == '0);
    assign total_upd = total_reg - TOT_W'(oldest) + TOT_W'(amp);
    assign mean_prod = MPROD_W'(total_reg) * MPROD_W'(MEAN_RECIP);

    always_comb
    begin
        state_next     = state_reg;
        dsum_next      = dsum_reg;
        count_next     = count_reg;
        hist_next      = hist_reg;
        total_next     = total_reg;
        zeros_next     = zeros_reg;
        iter_next      = iter_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        root_next      = root_reg;
        one_next       = one_reg;
        res_amp_next   = res_amp_reg;
        res_full_next  = res_full_reg;
        out_amp_next   = out_amp_reg;
        out_full_next  = out_full_reg;
        out_valid_next = out_valid_reg;

        if (levels.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_ACC:
            begin
                if (take)
                begin
                    if (count_reg < CNT_W'(MAX_BUFFER_SAMPLES))
                    begin
                        dsum_next  = dsum_reg + DSUM_W'(sq);
                        count_next = count_reg + 1'b1;
                    end
                    if (samples.last_in_buffer)
                    begin
                        state_next = S_SCALE;
                    end
                end
            end
            S_SCALE:
            begin
                rem_next   = NUM_W'(dsum_reg) << NUM_SHIFT;
                dsh_next   = NUM_W'(scale_prod) << DIV_LAST_BIT;
                quo_next   = '0;
                iter_next  = DIV_LAST_BIT;
                dsum_next  = '0;
                count_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sub_ok)
                begin
                    rem_next = sub_diff[NUM_W-1:0];
                end
                quo_next  = quo_step;
                dsh_next  = dsh_reg >> 1;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    rem_next   = NUM_W'(quo_step);
                    root_next  = '0;
                    one_next   = ROOT_ONE_INIT;
                    iter_next  = ROOT_STEPS;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (sub_ok)
                begin
                    rem_next  = sub_diff[NUM_W-1:0];
                    root_next = (root_reg >> 1) + one_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                one_next  = one_reg >> 2;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                begin
                    hist_next[i] = hist_reg[i+1];
                end
                hist_next[HISTORY_DEPTH-1] = amp;
                total_next = total_upd;
                zeros_next = zeros_upd;
                if (zeros_upd == '0)
                begin
                    state_next = S_MEAN;
                end
                else
                begin
                    res_amp_next  = amp;
                    res_full_next = 1'b0;
                    state_next    = S_OUT;
                end
            end
            S_MEAN:
            begin
                res_amp_next  = mean_prod[MEAN_SHIFT +: AMP_W];
                res_full_next = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_amp_next   = res_amp_reg;
                    out_full_next  = res_full_reg;
                    state_next     = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            dsum_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            zeros_reg     <= ZC_W'(HISTORY_DEPTH);
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            dsum_reg      <= dsum_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            zeros_reg     <= zeros_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        root_reg     <= root_next;
        one_reg      <= one_next;
        res_amp_reg  <= res_amp_next;
        res_full_reg <= res_full_next;
        out_amp_reg  <= out_amp_next;
        out_full_reg <= out_full_next;
    end

endmodule : rms_amplitude_meter
`default_nettype wire
